// ===== sv/ftsq_pkg.sv =====
package ftsq_pkg;

    localparam int LEVEL_W    = 16;
    localparam int RATE_W     = 19;
    localparam int ANGLE_W    = 17;
    localparam int DT_W       = 16;
    localparam int MODE_W     = 3;
    localparam int PHASE_W    = 3;
    localparam int EVENT_W    = 3;
    localparam int TIMER_W    = 24;
    localparam int TOTAL_W    = 32;
    localparam int LIMIT2_W   = 32;
    localparam int TILT2_W    = 34;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam logic [MODE_W-1:0] MODE_TICK      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TAKEOFF   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LANDING   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EMERGENCY = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RESET     = 3'd4;

    localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_TAKEOFF  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_HOVER    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LANDING  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_GROUNDED = 3'd4;

    localparam logic [EVENT_W-1:0] EV_NONE       = 3'd0;
    localparam logic [EVENT_W-1:0] EV_TO_START   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_TO_DONE    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_LAND_START = 3'd3;
    localparam logic [EVENT_W-1:0] EV_TOUCHDOWN  = 3'd4;
    localparam logic [EVENT_W-1:0] EV_EMERGENCY  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_TAKEOFF_LEVEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOVER_LEVEL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIMB_RATE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DESCENT_RATE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOUCHDOWN_LEVEL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EMERGENCY_TILT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DRIFT_TILT      = 3'd6;

    // 0.01 of full scale, and the 10 s landing limit in 1/65536 s
    localparam logic [LEVEL_W:0]    TOL        = 17'd328;
    localparam logic [TIMER_W-1:0]  LAND_LIMIT = 24'd655360;
    localparam logic [LEVEL_W-1:0]  FULL_SCALE = 16'd32768;

    localparam logic [LEVEL_W-1:0]  RST_TAKEOFF_LEVEL   = 16'd19661;
    localparam logic [LEVEL_W-1:0]  RST_HOVER_LEVEL     = 16'd16384;
    localparam logic [RATE_W-1:0]   RST_CLIMB_RATE      = 19'd16384;
    localparam logic [RATE_W-1:0]   RST_DESCENT_RATE    = 19'd6554;
    localparam logic [LEVEL_W-1:0]  RST_TOUCHDOWN_LEVEL = 16'd0;
    localparam logic [LIMIT2_W-1:0] RST_EMERGENCY_TILT2 = 32'd132710400;
    localparam logic [LIMIT2_W-1:0] RST_DRIFT_TILT2     = 32'd14745600;

    typedef struct packed {
        logic [LEVEL_W-1:0]  takeoff_level;
        logic [LEVEL_W-1:0]  hover_level;
        logic [RATE_W-1:0]   climb_rate;
        logic [RATE_W-1:0]   descent_rate;
        logic [LEVEL_W-1:0]  touchdown_level;
        logic [LIMIT2_W-1:0] emergency_tilt2;
        logic [LIMIT2_W-1:0] drift_tilt2;
    } t_cfg;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [TILT2_W-1:0] tilt2;
        logic [RATE_W-1:0]  step_up;
        logic [RATE_W-1:0]  step_down;
        logic [DT_W-1:0]    step_time;
    } t_prep;

    typedef struct packed {
        logic [LEVEL_W-1:0] throttle;
        logic [PHASE_W-1:0] phase_now;
        logic [EVENT_W-1:0] event_now;
        logic               accepted;
        logic [TOTAL_W-1:0] airborne_time;
    } t_result;

endpackage

// ===== sv/ftsq_cfg.sv =====
module ftsq_cfg import ftsq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready,
    output t_cfg                  o_cfg
);

    t_cfg                r_cfg;
    logic [LEVEL_W-1:0]  wr_level;
    logic [LIMIT2_W-1:0] wr_square;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // tilt limits are kept squared so the tick path compares sums of squares
    assign wr_level  = i_cfg_data[LEVEL_W-1:0];
    assign wr_square = LIMIT2_W'(wr_level) * LIMIT2_W'(wr_level);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.takeoff_level   <= RST_TAKEOFF_LEVEL;
            r_cfg.hover_level     <= RST_HOVER_LEVEL;
            r_cfg.climb_rate      <= RST_CLIMB_RATE;
            r_cfg.descent_rate    <= RST_DESCENT_RATE;
            r_cfg.touchdown_level <= RST_TOUCHDOWN_LEVEL;
            r_cfg.emergency_tilt2 <= RST_EMERGENCY_TILT2;
            r_cfg.drift_tilt2     <= RST_DRIFT_TILT2;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TAKEOFF_LEVEL:   r_cfg.takeoff_level   <= wr_level;
                REG_HOVER_LEVEL:     r_cfg.hover_level     <= wr_level;
                REG_CLIMB_RATE:      r_cfg.climb_rate      <= i_cfg_data;
                REG_DESCENT_RATE:    r_cfg.descent_rate    <= i_cfg_data;
                REG_TOUCHDOWN_LEVEL: r_cfg.touchdown_level <= wr_level;
                REG_EMERGENCY_TILT:  r_cfg.emergency_tilt2 <= wr_square;
                REG_DRIFT_TILT:      r_cfg.drift_tilt2     <= wr_square;
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== sv/ftsq_prep.sv =====
module ftsq_prep import ftsq_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [MODE_W-1:0]         i_mode,
    input  logic signed [ANGLE_W-1:0] i_roll,
    input  logic signed [ANGLE_W-1:0] i_pitch,
    input  logic [DT_W-1:0]           i_step_time,
    input  t_cfg                      i_cfg,
    input  logic                      i_take,
    output logic                      o_valid,
    output t_prep                     o_prep
);

    localparam int PROD_W = RATE_W + DT_W;

    logic                 r_valid;
    t_prep                r_prep;
    logic [ANGLE_W-1:0]   roll_mag;
    logic [ANGLE_W-1:0]   pitch_mag;
    logic [TILT2_W-1:0]   tilt2;
    logic [PROD_W-1:0]    up_prod;
    logic [PROD_W-1:0]    down_prod;
    logic                 in_fire;

    assign o_in_ready = !r_valid || i_take;
    assign in_fire    = i_in_valid && o_in_ready;
    assign o_valid    = r_valid;
    assign o_prep     = r_prep;

    // magnitude fits 17 bits unsigned, the most negative angle included
    assign roll_mag  = i_roll[ANGLE_W-1]  ? ANGLE_W'(-i_roll)  : ANGLE_W'(i_roll);
    assign pitch_mag = i_pitch[ANGLE_W-1] ? ANGLE_W'(-i_pitch) : ANGLE_W'(i_pitch);
    assign tilt2     = TILT2_W'(roll_mag) * TILT2_W'(roll_mag)
                     + TILT2_W'(pitch_mag) * TILT2_W'(pitch_mag);

    assign up_prod   = PROD_W'(i_cfg.climb_rate) * PROD_W'(i_step_time);
    assign down_prod = PROD_W'(i_cfg.descent_rate) * PROD_W'(i_step_time);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_fire) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_prep.mode      <= i_mode;
            r_prep.tilt2     <= tilt2;
            r_prep.step_up   <= up_prod[PROD_W-1:DT_W];
            r_prep.step_down <= down_prod[PROD_W-1:DT_W];
            r_prep.step_time <= i_step_time;
        end
    end

endmodule

// ===== sv/ftsq_core.sv =====
module ftsq_core import ftsq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_prep   i_prep,
    input  t_cfg    i_cfg,
    output logic    o_take,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_res
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [LEVEL_W-1:0] r_goal,  n_goal;
    logic               r_ramp,  n_ramp;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic [TOTAL_W-1:0] r_flight, n_flight;
    logic [EVENT_W-1:0] r_event, n_event;
    logic               n_ok;
    logic               r_out_valid;
    t_result            r_res;

    logic               over_emg;
    logic               over_drift;
    logic [LEVEL_W-1:0] level_up;
    logic [LEVEL_W-1:0] level_down;
    logic [LEVEL_W-1:0] up_gap;
    logic [TOTAL_W:0]   flight_sum;
    logic [TOTAL_W-1:0] flight_sat;
    logic [LEVEL_W:0]   touch_limit;

    function automatic logic [LEVEL_W-1:0] ramp_to(
        input logic [LEVEL_W-1:0] cur,
        input logic [LEVEL_W-1:0] goal,
        input logic [RATE_W-1:0]  step
    );
        logic [LEVEL_W-1:0] result;
        if (cur < goal) begin
            if (RATE_W'(goal - cur) <= step) begin
                result = goal;
            end else begin
                result = LEVEL_W'(RATE_W'(cur) + step);
            end
        end else if (cur > goal) begin
            if (RATE_W'(cur - goal) <= step) begin
                result = goal;
            end else begin
                result = LEVEL_W'(RATE_W'(cur) - step);
            end
        end else begin
            result = cur;
        end
        return result;
    endfunction

    assign o_take      = i_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    assign over_emg    = i_prep.tilt2 > TILT2_W'(i_cfg.emergency_tilt2);
    assign over_drift  = i_prep.tilt2 > TILT2_W'(i_cfg.drift_tilt2);
    assign level_up    = ramp_to(r_level, r_goal, i_prep.step_up);
    assign level_down  = ramp_to(r_level, '0, i_prep.step_down);
    assign up_gap      = (level_up > r_goal) ? level_up - r_goal : r_goal - level_up;
    assign flight_sum  = (TOTAL_W + 1)'(r_flight) + (TOTAL_W + 1)'(i_prep.step_time);
    assign flight_sat  = flight_sum[TOTAL_W] ? '1 : flight_sum[TOTAL_W-1:0];
    assign touch_limit = (LEVEL_W + 1)'(i_cfg.touchdown_level) + TOL;

    always_comb begin
        logic [TIMER_W:0] timer_sum;
        logic [LEVEL_W-1:0] land_level;
        n_phase  = r_phase;
        n_level  = r_level;
        n_goal   = r_goal;
        n_ramp   = r_ramp;
        n_timer  = r_timer;
        n_flight = r_flight;
        n_event  = r_event;
        n_ok     = 1'b0;
        timer_sum  = '0;
        land_level = r_level;
        case (i_prep.mode)
            MODE_TICK: begin
                n_ok = 1'b1;
                if ((r_phase == PH_TAKEOFF || r_phase == PH_HOVER) && over_emg) begin
                    n_phase = PH_GROUNDED;
                    n_level = '0;
                    n_goal  = '0;
                    n_ramp  = 1'b0;
                    n_event = EV_EMERGENCY;
                end else begin
                    // drift in hover starts a landing and falls into the landing step
                    if (r_phase == PH_HOVER && over_drift) begin
                        n_phase = PH_LANDING;
                        n_goal  = '0;
                        n_ramp  = 1'b1;
                        n_timer = '0;
                        n_event = EV_LAND_START;
                    end
                    case (n_phase)
                        PH_TAKEOFF: begin
                            if (r_ramp) begin
                                n_level = level_up;
                                if ((LEVEL_W + 1)'(up_gap) < TOL) begin
                                    n_phase = PH_HOVER;
                                    n_goal  = i_cfg.hover_level;
                                    n_event = EV_TO_DONE;
                                end
                            end
                            n_flight = flight_sat;
                        end
                        PH_HOVER: begin
                            n_level  = i_cfg.hover_level;
                            n_flight = flight_sat;
                        end
                        PH_LANDING: begin
                            timer_sum = (TIMER_W + 1)'(n_timer)
                                      + (TIMER_W + 1)'(i_prep.step_time);
                            n_timer   = timer_sum[TIMER_W] ? '1 : timer_sum[TIMER_W-1:0];
                            n_flight  = flight_sat;
                            if (n_ramp) begin
                                land_level = level_down;
                            end
                            n_level = land_level;
                            if ((LEVEL_W + 1)'(land_level) <= touch_limit) begin
                                n_phase = PH_GROUNDED;
                                n_level = '0;
                                n_ramp  = 1'b0;
                                n_event = EV_TOUCHDOWN;
                            end
                            // time limit forces touchdown but leaves the ramp flag
                            if (n_timer > LAND_LIMIT) begin
                                n_phase = PH_GROUNDED;
                                n_level = '0;
                                n_event = EV_TOUCHDOWN;
                            end
                        end
                        default: begin
                            n_level = '0;
                        end
                    endcase
                end
            end
            MODE_TAKEOFF: begin
                if (r_phase == PH_IDLE) begin
                    n_phase = PH_TAKEOFF;
                    n_level = '0;
                    n_goal  = i_cfg.takeoff_level;
                    n_ramp  = 1'b1;
                    n_event = EV_TO_START;
                    n_ok    = 1'b1;
                end
            end
            MODE_LANDING: begin
                if (r_phase == PH_HOVER || r_phase == PH_TAKEOFF) begin
                    n_phase = PH_LANDING;
                    n_goal  = '0;
                    n_ramp  = 1'b1;
                    n_timer = '0;
                    n_event = EV_LAND_START;
                    n_ok    = 1'b1;
                end
            end
            MODE_EMERGENCY: begin
                n_phase = PH_GROUNDED;
                n_level = '0;
                n_goal  = '0;
                n_ramp  = 1'b0;
                n_event = EV_EMERGENCY;
                n_ok    = 1'b1;
            end
            MODE_RESET: begin
                n_phase = PH_IDLE;
                n_level = '0;
                n_goal  = '0;
                n_ramp  = 1'b0;
                n_timer = '0;
                n_event = EV_NONE;
                n_ok    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_level     <= '0;
            r_goal      <= '0;
            r_ramp      <= 1'b0;
            r_timer     <= '0;
            r_flight    <= '0;
            r_event     <= EV_NONE;
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_phase     <= n_phase;
            r_level     <= n_level;
            r_goal      <= n_goal;
            r_ramp      <= n_ramp;
            r_timer     <= n_timer;
            r_flight    <= n_flight;
            r_event     <= n_event;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res.throttle      <= (n_level > FULL_SCALE) ? FULL_SCALE : n_level;
            r_res.phase_now     <= n_phase;
            r_res.event_now     <= n_event;
            r_res.accepted      <= n_ok;
            r_res.airborne_time <= n_flight;
        end
    end

endmodule

// ===== sv/flight_phase_throttle_sequencer.sv =====
// Drone flight-phase sequencer (idle, takeoff, hover, landing, grounded) that
// turns ticks and commands into a throttle, phase, event and flight time.
// One item per clock is sustained while the result side takes results; each
// item passes the input register, which holds the tilt squares and ramp steps
// (the multipliers), and then the result register, which follows one pass of
// phase logic over the stored state.
// Configuration writes take effect for the next item; write only while no
// item is in flight. Tilt limits are stored squared.
module flight_phase_throttle_sequencer import ftsq_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [MODE_W-1:0]         i_mode,
    input  logic signed [ANGLE_W-1:0] i_roll,
    input  logic signed [ANGLE_W-1:0] i_pitch,
    input  logic [DT_W-1:0]           i_step_time,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [LEVEL_W-1:0]        o_throttle,
    output logic [PHASE_W-1:0]        o_phase_now,
    output logic [EVENT_W-1:0]        o_event_now,
    output logic                      o_accepted,
    output logic [TOTAL_W-1:0]        o_airborne_time,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    t_cfg    cfg;
    t_prep   prep;
    logic    prep_valid;
    logic    take;
    t_result res;

    ftsq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    ftsq_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_roll      (i_roll),
        .i_pitch     (i_pitch),
        .i_step_time (i_step_time),
        .i_cfg       (cfg),
        .i_take      (take),
        .o_valid     (prep_valid),
        .o_prep      (prep)
    );

    ftsq_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (prep_valid),
        .i_prep      (prep),
        .i_cfg       (cfg),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (res)
    );

    assign o_throttle      = res.throttle;
    assign o_phase_now     = res.phase_now;
    assign o_event_now     = res.event_now;
    assign o_accepted      = res.accepted;
    assign o_airborne_time = res.airborne_time;

    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while result register is empty");

    a_ground_no_throttle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_phase_now == PH_IDLE || o_phase_now == PH_GROUNDED)
            |-> o_throttle == '0)
        else $error("throttle nonzero on the ground");

    a_emergency_grounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_now == EV_EMERGENCY
            |-> o_phase_now == PH_GROUNDED && o_throttle == '0)
        else $error("emergency event without grounded cutoff");

    a_takeoff_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_now == EV_TO_START |-> o_phase_now == PH_TAKEOFF)
        else $error("takeoff start event outside takeoff phase");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import ftsq_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int ANGLE_MAX    = 46080;
    // modes the block must ignore
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [ANGLE_W-1:0] roll;
        logic [ANGLE_W-1:0] pitch;
        logic [DT_W-1:0]    step_time;
    } flight_cmd_t;

    class flight_scoreboard;
        logic [LEVEL_W-1:0] takeoff_cfg, hover_cfg, touch_cfg, emg_cfg, drift_cfg;
        logic [RATE_W-1:0]  climb_cfg, descent_cfg;
        logic [PHASE_W-1:0] phase;
        logic [LEVEL_W-1:0] level, goal;
        bit                 ramping;
        logic [TIMER_W-1:0] descent_t;
        logic [TOTAL_W-1:0] flown;
        logic [EVENT_W-1:0] last_ev;
        t_result            status_due[$];
        int                 faults;

        function new();
            takeoff_cfg = 16'd19661;
            hover_cfg   = 16'd16384;
            climb_cfg   = 19'd16384;
            descent_cfg = 19'd6554;
            touch_cfg   = 16'd0;
            emg_cfg     = 16'd11520;
            drift_cfg   = 16'd3840;
            phase       = PH_IDLE;
            level       = '0;
            goal        = '0;
            ramping     = 0;
            descent_t   = '0;
            flown       = '0;
            last_ev     = EV_NONE;
            faults      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_TAKEOFF_LEVEL:   takeoff_cfg = val[LEVEL_W-1:0];
                REG_HOVER_LEVEL:     hover_cfg   = val[LEVEL_W-1:0];
                REG_CLIMB_RATE:      climb_cfg   = val[RATE_W-1:0];
                REG_DESCENT_RATE:    descent_cfg = val[RATE_W-1:0];
                REG_TOUCHDOWN_LEVEL: touch_cfg   = val[LEVEL_W-1:0];
                REG_EMERGENCY_TILT:  emg_cfg     = val[LEVEL_W-1:0];
                REG_DRIFT_TILT:      drift_cfg   = val[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned tilt_square(logic [ANGLE_W-1:0] a);
            logic [ANGLE_W-1:0] m;
            longint unsigned    mm;
            m = a;
            if (m[ANGLE_W-1]) m = ~m + 1'b1;
            mm = m;
            return mm * mm;
        endfunction

        function longint unsigned clamp_sum(longint unsigned a, longint unsigned b,
                                            longint unsigned cap);
            longint unsigned s;
            s = a + b;
            return (s > cap) ? cap : s;
        endfunction

        function logic [LEVEL_W-1:0] ramp_level(logic [LEVEL_W-1:0] cur,
                                                logic [LEVEL_W-1:0] target,
                                                logic [RATE_W-1:0] rate,
                                                logic [DT_W-1:0] dt);
            longint unsigned r, d, stride;
            r = rate;
            d = dt;
            stride = (r * d) >> 16;
            if (cur < target) return (target - cur <= stride) ? target : cur + stride[15:0];
            if (cur > target) return (cur - target <= stride) ? target : cur - stride[15:0];
            return cur;
        endfunction

        function void begin_landing();
            phase     = PH_LANDING;
            goal      = '0;
            ramping   = 1;
            descent_t = '0;
            last_ev   = EV_LAND_START;
        endfunction

        function void ground_hard();
            phase   = PH_GROUNDED;
            level   = '0;
            goal    = '0;
            ramping = 0;
            last_ev = EV_EMERGENCY;
        endfunction

        function void fly_tick(logic [ANGLE_W-1:0] roll, logic [ANGLE_W-1:0] pitch,
                               logic [DT_W-1:0] dt);
            longint unsigned tilt2, emg2, drf2, lim, off;
            tilt2 = tilt_square(roll) + tilt_square(pitch);
            lim = emg_cfg;
            emg2 = lim * lim;
            lim = drift_cfg;
            drf2 = lim * lim;
            if ((phase == PH_TAKEOFF || phase == PH_HOVER) && tilt2 > emg2) begin
                ground_hard();
                return;
            end
            if (phase == PH_HOVER && tilt2 > drf2) begin_landing();
            case (phase)
                PH_TAKEOFF: begin
                    if (ramping) begin
                        level = ramp_level(level, goal, climb_cfg, dt);
                        off = (level > goal) ? level - goal : goal - level;
                        if (off < TOL) begin
                            phase   = PH_HOVER;
                            goal    = hover_cfg;
                            last_ev = EV_TO_DONE;
                        end
                    end
                    flown = clamp_sum(flown, dt, 32'hFFFF_FFFF);
                end
                PH_HOVER: begin
                    level = hover_cfg;
                    flown = clamp_sum(flown, dt, 32'hFFFF_FFFF);
                end
                PH_LANDING: begin
                    descent_t = clamp_sum(descent_t, dt, 24'hFF_FFFF);
                    flown = clamp_sum(flown, dt, 32'hFFFF_FFFF);
                    if (ramping) level = ramp_level(level, '0, descent_cfg, dt);
                    if ({1'b0, level} <= {1'b0, touch_cfg} + TOL) begin
                        phase   = PH_GROUNDED;
                        level   = '0;
                        ramping = 0;
                        last_ev = EV_TOUCHDOWN;
                    end
                    // time-limit touchdown leaves the ramp flag alone
                    if (descent_t > LAND_LIMIT) begin
                        phase   = PH_GROUNDED;
                        level   = '0;
                        last_ev = EV_TOUCHDOWN;
                    end
                end
                default: level = '0;
            endcase
        endfunction

        function t_result fly(flight_cmd_t c);
            t_result r;
            bit      honoured;
            honoured = 0;
            case (c.mode)
                MODE_TICK: begin
                    fly_tick(c.roll, c.pitch, c.step_time);
                    honoured = 1;
                end
                MODE_TAKEOFF: begin
                    if (phase == PH_IDLE) begin
                        phase    = PH_TAKEOFF;
                        level    = '0;
                        goal     = takeoff_cfg;
                        ramping  = 1;
                        last_ev  = EV_TO_START;
                        honoured = 1;
                    end
                end
                MODE_LANDING: begin
                    if (phase == PH_HOVER || phase == PH_TAKEOFF) begin
                        begin_landing();
                        honoured = 1;
                    end
                end
                MODE_EMERGENCY: begin
                    ground_hard();
                    honoured = 1;
                end
                MODE_RESET: begin
                    // flight time survives a reset command
                    phase     = PH_IDLE;
                    level     = '0;
                    goal      = '0;
                    ramping   = 0;
                    descent_t = '0;
                    last_ev   = EV_NONE;
                    honoured  = 1;
                end
                default: ;
            endcase
            r.throttle      = (level > FULL_SCALE) ? FULL_SCALE : level;
            r.phase_now     = phase;
            r.event_now     = last_ev;
            r.accepted      = honoured;
            r.airborne_time = flown;
            return r;
        endfunction

        function void note(flight_cmd_t c);
            status_due.push_back(fly(c));
        endfunction

        function void check(t_result got);
            t_result want;
            if (status_due.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected status: thr %0d ph %0d ev %0d acc %0d air %0d",
                             got.throttle, got.phase_now, got.event_now, got.accepted,
                             got.airborne_time);
                return;
            end
            want = status_due.pop_front();
            if (got !== want) begin
                faults++;
                if (faults <= 10)
                    $display({"status mismatch: thr %0d/%0d ph %0d/%0d ev %0d/%0d",
                              " acc %0d/%0d air %0d/%0d"},
                             want.throttle, got.throttle, want.phase_now, got.phase_now,
                             want.event_now, got.event_now, want.accepted, got.accepted,
                             want.airborne_time, got.airborne_time);
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   in_valid;
    logic                   o_in_ready;
    logic [MODE_W-1:0]      in_mode;
    logic [ANGLE_W-1:0]     in_roll;
    logic [ANGLE_W-1:0]     in_pitch;
    logic [DT_W-1:0]        in_step;
    logic                   o_out_valid;
    logic                   out_ready;
    logic [LEVEL_W-1:0]     o_throttle;
    logic [PHASE_W-1:0]     o_phase_now;
    logic [EVENT_W-1:0]     o_event_now;
    logic                   o_accepted;
    logic [TOTAL_W-1:0]     o_airborne_time;
    logic                   cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    flight_scoreboard board = new();
    bit quiet;
    bit hold_req;
    bit hold_done;
    int cycles;

    flight_phase_throttle_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (in_mode),
        .i_roll          (in_roll),
        .i_pitch         (in_pitch),
        .i_step_time     (in_step),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_throttle      (o_throttle),
        .o_phase_now     (o_phase_now),
        .o_event_now     (o_event_now),
        .o_accepted      (o_accepted),
        .o_airborne_time (o_airborne_time),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (cfg_valid && o_cfg_ready) board.write_reg(cfg_index, cfg_data);
            if (in_valid && o_in_ready) board.note({in_mode, in_roll, in_pitch, in_step});
            if (o_out_valid && out_ready) begin
                got.throttle      = o_throttle;
                got.phase_now     = o_phase_now;
                got.event_now     = o_event_now;
                got.accepted      = o_accepted;
                got.airborne_time = o_airborne_time;
                board.check(got);
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        out_ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                out_ready <= quiet || ($urandom_range(99) >= 6);
            end
        end
    end

    function automatic flight_cmd_t cmd(logic [MODE_W-1:0] mode, int roll, int pitch,
                                        int dt);
        flight_cmd_t c;
        c.mode      = mode;
        c.roll      = roll[ANGLE_W-1:0];
        c.pitch     = pitch[ANGLE_W-1:0];
        c.step_time = dt[DT_W-1:0];
        return c;
    endfunction

    function automatic int spread(int mag);
        return int'($urandom_range(0, 2 * mag)) - mag;
    endfunction

    function automatic int with_sign(int mag);
        return $urandom_range(1) ? -mag : mag;
    endfunction

    function automatic flight_cmd_t pick_item();
        flight_cmd_t c;
        int r, lim_d, lim_e, m, roll, pitch, dt;
        r = $urandom_range(99);
        c.mode = MODE_TICK;
        case (board.phase)
            PH_IDLE: begin
                if (r < 75) c.mode = MODE_TAKEOFF;
                else if (r >= 85) c.mode = MODE_W'($urandom_range(7));
            end
            PH_TAKEOFF, PH_HOVER: begin
                if (r >= 93) c.mode = MODE_W'($urandom_range(7));
                else if (r >= 88) c.mode = MODE_LANDING;
            end
            PH_LANDING: begin
                if (r >= 92) c.mode = MODE_W'($urandom_range(7));
            end
            default: begin
                if (r < 60) c.mode = MODE_RESET;
                else if (r >= 80) c.mode = MODE_W'($urandom_range(7));
            end
        endcase

        lim_d = (board.drift_cfg > ANGLE_MAX) ? ANGLE_MAX : int'(board.drift_cfg);
        lim_e = (board.emg_cfg > ANGLE_MAX) ? ANGLE_MAX : int'(board.emg_cfg);
        r = $urandom_range(99);
        if (r < 70) begin
            roll  = spread(lim_d / 2);
            pitch = spread(lim_d / 2);
        end else if (r < 85) begin
            roll  = with_sign($urandom_range(lim_d, lim_e));
            pitch = spread(lim_d / 4);
        end else if (r < 93) begin
            // sit on a limit or just past it
            m = $urandom_range(1) ? lim_e : lim_d;
            if (m < ANGLE_MAX) m += $urandom_range(1);
            roll  = with_sign(m);
            pitch = 0;
            if ($urandom_range(1)) begin
                pitch = roll;
                roll  = 0;
            end
        end else begin
            roll  = spread(ANGLE_MAX);
            pitch = spread(ANGLE_MAX);
        end

        r = $urandom_range(99);
        if (r < 60) dt = $urandom_range(65535);
        else if (r < 80) dt = $urandom_range(2000);
        else if (r < 90) dt = 65535;
        else if (r < 95) dt = 0;
        else dt = $urandom_range(1, 16);

        c.roll      = roll[ANGLE_W-1:0];
        c.pitch     = pitch[ANGLE_W-1:0];
        c.step_time = dt[DT_W-1:0];
        return c;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input flight_cmd_t c);
        if (!quiet && $urandom_range(99) < 4) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_mode  <= c.mode;
        in_roll  <= c.roll;
        in_pitch <= c.pitch;
        in_step  <= c.step_time;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.status_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_regs(input int takeoff, input int hover, input int climb,
                            input int descent, input int touch, input int emg,
                            input int drift);
        drain();
        put_reg(REG_TAKEOFF_LEVEL, takeoff);
        put_reg(REG_HOVER_LEVEL, hover);
        put_reg(REG_CLIMB_RATE, climb);
        put_reg(REG_DESCENT_RATE, descent);
        put_reg(REG_TOUCHDOWN_LEVEL, touch);
        put_reg(REG_EMERGENCY_TILT, emg);
        put_reg(REG_DRIFT_TILT, drift);
        cfg_valid <= 1'b0;
    endtask

    task automatic fly_random(input int n);
        for (int i = 0; i < n; i++) send_item(pick_item());
    endtask

    task automatic run_directed();
        send_item(cmd(MODE_TICK, -46080, 46080, 65535));
        send_item(cmd(MODE_LANDING, 0, 0, 0));
        send_item(cmd(MODE_UNUSED_LO, 46080, -46080, 65535));
        send_item(cmd(MODE_UNUSED_HI, 0, 0, 0));
        send_item(cmd(MODE_TAKEOFF, 0, 0, 0));
        send_item(cmd(MODE_TAKEOFF, 0, 0, 0));
        // tilt exactly at the emergency limit does not trip
        send_item(cmd(MODE_TICK, 11520, 0, 0));
        send_item(cmd(MODE_TICK, 0, -11520, 65535));
        send_item(cmd(MODE_TICK, 0, 0, 65535));
        send_item(cmd(MODE_TICK, -3840, 0, 1000));
        // just past drift: automatic landing
        send_item(cmd(MODE_TICK, 0, 3841, 65535));
        send_item(cmd(MODE_TICK, 46080, -46080, 65535));
        send_item(cmd(MODE_TICK, 0, 0, 65535));
        send_item(cmd(MODE_TICK, 0, 0, 65535));
        send_item(cmd(MODE_LANDING, 0, 0, 0));
        send_item(cmd(MODE_TAKEOFF, 0, 0, 0));
        send_item(cmd(MODE_RESET, 0, 0, 0));
        send_item(cmd(MODE_TAKEOFF, 0, 0, 0));
        send_item(cmd(MODE_TICK, 0, 0, 3000));
        send_item(cmd(MODE_LANDING, 0, 0, 0));
        send_item(cmd(MODE_EMERGENCY, 0, 0, 0));
        send_item(cmd(MODE_RESET, 0, 0, 0));
        send_item(cmd(MODE_TAKEOFF, 0, 0, 0));
        send_item(cmd(MODE_TICK, -11521, 0, 500));
        send_item(cmd(MODE_RESET, 0, 0, 0));
        send_item(cmd(MODE_EMERGENCY, 0, 0, 0));
        send_item(cmd(MODE_RESET, 0, 0, 0));
    endtask

    initial begin
        int e;
        i_rst_n   <= 1'b0;
        in_valid  <= 1'b0;
        in_mode   <= MODE_TICK;
        in_roll   <= '0;
        in_pitch  <= '0;
        in_step   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_TAKEOFF_LEVEL;
        cfg_data  <= '0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        hold_done = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        for (int i = 0; i < 300; i++) begin
            quiet = (i >= 100 && i < 250);
            if (i == 40) hold_req = 1'b1;
            // hold the sender until every status is back
            if (i == 200) drain();
            send_item(pick_item());
        end
        quiet = 1'b0;

        set_regs(32768, 32768, 327680, 327680, 32768, 46080, 46080);
        fly_random(170);
        set_regs(0, 0, 0, 0, 0, 0, 0);
        fly_random(170);
        // no descent ramp: landings end on the time limit
        set_regs(32768, 30000, 20000, 0, 0, 46080, 20000);
        fly_random(170);
        // beyond full scale: throttle must clamp
        set_regs(50000, 65535, 524287, 524287, 65535, 65535, 65535);
        fly_random(170);
        set_regs(50000, 40000, 9000, 3000, 0, 30000, 5000);
        fly_random(170);
        for (int k = 0; k < 4; k++) begin
            e = $urandom_range(46080);
            set_regs($urandom_range(32768), $urandom_range(32768), $urandom_range(327680),
                     $urandom_range(327680), $urandom_range(k[0] ? 32768 : 2000), e,
                     $urandom_range(1) ? $urandom_range(46080) : $urandom_range(e));
            fly_random(150);
        end

        // hover at full step time
        set_regs(19661, 16384, 327680, 6554, 0, 11520, 3840);
        send_item(cmd(MODE_RESET, 0, 0, 0));
        send_item(cmd(MODE_TAKEOFF, 0, 0, 0));
        for (int i = 0; i < 20; i++) send_item(cmd(MODE_TICK, 0, 0, 65535));
        send_item(cmd(MODE_RESET, 0, 0, 0));
        send_item(cmd(MODE_TAKEOFF, 0, 0, 0));
        send_item(cmd(MODE_TICK, 0, 0, 65535));

        drain();
        repeat (10) @(negedge i_clk);
        if (board.faults == 0 && board.status_due.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
